// ----- src/gwb_pkg.sv -----
// ----------------------------------------------------------------------------
// gwb_pkg
// Shared widths, mode codes and lane control type for the gray-world white
// balance block.
// ----------------------------------------------------------------------------
package gwb_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 28;
    localparam int TOT_W     = 30;
    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 16;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_ACCUM   = 2'd1;
    localparam logic [1:0] MODE_CORRECT = 2'd2;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef struct packed {
        logic clr;
        logic acc;
        logic load_div;
        logic init;
        logic step;
        logic commit;
    } t_lane_ctl;

endpackage

// ----- src/gwb_in_if.sv -----
// ----------------------------------------------------------------------------
// gwb_in_if
// Input pixel channel: mode code and one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface gwb_in_if
    import gwb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output mode, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input mode, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

// ----- src/gwb_out_if.sv -----
// ----------------------------------------------------------------------------
// gwb_out_if
// Output pixel channel: one balanced RGB pixel per beat.
// ----------------------------------------------------------------------------
interface gwb_out_if
    import gwb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, output ready);
endinterface

// ----- src/gwb_lane.sv -----
// ----------------------------------------------------------------------------
// gwb_lane
// One color channel: saturating sum, bit-serial gain divider and the
// gain multiply with clamp to the pixel range.
// ----------------------------------------------------------------------------
module gwb_lane
    import gwb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic [PIX_W-1:0] i_add,
    input  logic [PIX_W-1:0] i_comp,
    input  logic [TOT_W-1:0] i_total,
    output logic [SUM_W-1:0] o_sum,
    output logic [PIX_W-1:0] o_res
);

    logic [SUM_W-1:0]        r_sum;
    logic [GAIN_W-1:0]       r_gain;
    logic [TOT_W-1:0]        r_div;
    logic [TOT_W-1:0]        r_rem;
    logic [GAIN_W-1:0]       r_dvd;
    logic [GAIN_W-1:0]       r_quo;
    logic                    r_ovf;
    logic                    r_zero;

    logic [SUM_W:0]          w_acc;
    logic [SUM_W-1:0]        n_sum;
    logic [TOT_W:0]          w_trial;
    logic                    w_ge;
    logic [TOT_W:0]          w_diff;
    logic [TOT_W-1:0]        n_rem;
    logic [GAIN_W-1:0]       n_quo;
    logic [GAIN_W-1:0]       n_gain;
    logic [PIX_W+GAIN_W-1:0] w_prod;
    logic [GAIN_W-GAIN_FRAC+PIX_W-1:0] w_int;

    // saturating accumulate
    assign w_acc = {1'b0, r_sum} + {{(SUM_W+1-PIX_W){1'b0}}, i_add};
    assign n_sum = w_acc[SUM_W] ? SUM_MAX : w_acc[SUM_W-1:0];

    // restoring division step
    assign w_trial = {r_rem, r_dvd[GAIN_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[TOT_W-1:0] : w_trial[TOT_W-1:0];
    assign n_quo   = {r_quo[GAIN_W-2:0], w_ge};
    assign n_gain  = r_zero ? '0 : (r_ovf ? GAIN_MAX : n_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_gain <= '0;
        end else begin
            if (i_ctl.clr) begin
                r_sum <= '0;
            end else if (i_ctl.acc) begin
                r_sum <= n_sum;
            end
            if (i_ctl.commit) begin
                r_gain <= n_gain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_div) begin
            r_div <= {2'b00, r_sum} + {1'b0, r_sum, 1'b0};
        end
        if (i_ctl.init) begin
            r_ovf  <= {8'd0, i_total} >= {r_div, 8'd0};
            r_zero <= (r_div == '0);
            r_rem  <= {8'd0, i_total[TOT_W-1:8]};
            r_dvd  <= {i_total[7:0], {GAIN_FRAC{1'b0}}};
            r_quo  <= '0;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[GAIN_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    // gain multiply, fraction dropped, clamp
    assign w_prod = {{GAIN_W{1'b0}}, i_comp} * {{PIX_W{1'b0}}, r_gain};
    assign w_int  = w_prod[PIX_W+GAIN_W-1:GAIN_FRAC];
    assign o_res  = (w_int > {{(GAIN_W-GAIN_FRAC){1'b0}}, {PIX_W{1'b1}}}) ?
                    {PIX_W{1'b1}} : w_int[PIX_W-1:0];
    assign o_sum  = r_sum;

endmodule

// ----- src/gray_world_white_balance.sv -----
// ----------------------------------------------------------------------------
// gray_world_white_balance
// Gray-world auto white balance: three channel lanes gather sums and derive
// per-channel gains; the merge stage registers the balanced pixel.
//
//   channel  dir  beat contents
//   i_pix    in   mode, red_in, green_in, blue_in
//   o_pix    out  red_out, green_out, blue_out
//
// clear and accumulate beats are taken back to back while o_pix does not stall
// a correct beat with current gains goes straight into the output register
// the first correct beat after a clear or accumulate first computes gains:
// one setup state and 24 steps of the per-lane bit-serial gain divider
// reset is synchronous, active low; sums and gains come up zero
// i_pix stalls while the divider runs or a result waits on a stalled o_pix
// ----------------------------------------------------------------------------
module gray_world_white_balance
    import gwb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gwb_in_if.sink    i_pix,
    gwb_out_if.source o_pix
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_gvalid;
    logic [TOT_W-1:0] r_total;
    logic [PIX_W-1:0] r_pix_r;
    logic [PIX_W-1:0] r_pix_g;
    logic [PIX_W-1:0] r_pix_b;
    logic             r_ovalid;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;

    logic             w_fire;
    logic             w_direct;
    logic             w_start;
    logic             w_load;
    logic             w_last;
    t_lane_ctl        w_ctl;
    logic [PIX_W-1:0] w_comp_r;
    logic [PIX_W-1:0] w_comp_g;
    logic [PIX_W-1:0] w_comp_b;
    logic [SUM_W-1:0] w_sum_r;
    logic [SUM_W-1:0] w_sum_g;
    logic [SUM_W-1:0] w_sum_b;
    logic [PIX_W-1:0] w_res_r;
    logic [PIX_W-1:0] w_res_g;
    logic [PIX_W-1:0] w_res_b;

    assign i_pix.ready = (r_state == ST_IDLE) && (!r_ovalid || o_pix.ready);
    assign w_fire      = i_pix.valid && i_pix.ready;
    assign w_direct    = w_fire && (i_pix.mode == MODE_CORRECT) && r_gvalid;
    assign w_start     = w_fire && (i_pix.mode == MODE_CORRECT) && !r_gvalid;
    assign w_last      = (r_state == ST_RUN) && (r_cnt == '0);
    assign w_load      = w_direct || (r_state == ST_OUT);

    always_comb begin
        w_ctl          = '0;
        w_ctl.clr      = w_fire && (i_pix.mode == MODE_CLEAR);
        w_ctl.acc      = w_fire && (i_pix.mode == MODE_ACCUM);
        w_ctl.load_div = w_start;
        w_ctl.init     = (r_state == ST_INIT);
        w_ctl.step     = (r_state == ST_RUN);
        w_ctl.commit   = w_last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: n_state = ST_RUN;
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_comp_r = (r_state == ST_OUT) ? r_pix_r : i_pix.red_in;
    assign w_comp_g = (r_state == ST_OUT) ? r_pix_g : i_pix.green_in;
    assign w_comp_b = (r_state == ST_OUT) ? r_pix_b : i_pix.blue_in;

    gwb_lane u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_add   (i_pix.red_in),
        .i_comp  (w_comp_r),
        .i_total (r_total),
        .o_sum   (w_sum_r),
        .o_res   (w_res_r)
    );

    gwb_lane u_lane_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_add   (i_pix.green_in),
        .i_comp  (w_comp_g),
        .i_total (r_total),
        .o_sum   (w_sum_g),
        .o_res   (w_res_g)
    );

    gwb_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_add   (i_pix.blue_in),
        .i_comp  (w_comp_b),
        .i_total (r_total),
        .o_sum   (w_sum_b),
        .o_res   (w_res_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_gvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT) begin
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_ctl.clr || w_ctl.acc) begin
                r_gvalid <= 1'b0;
            end else if (w_last) begin
                r_gvalid <= 1'b1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_total <= {2'b00, w_sum_r} + {2'b00, w_sum_g} + {2'b00, w_sum_b};
            r_pix_r <= i_pix.red_in;
            r_pix_g <= i_pix.green_in;
            r_pix_b <= i_pix.blue_in;
        end
        if (w_load) begin
            r_red   <= w_res_r;
            r_green <= w_res_g;
            r_blue  <= w_res_b;
        end
    end

    assign o_pix.valid     = r_ovalid;
    assign o_pix.red_out   = r_red;
    assign o_pix.green_out = r_green;
    assign o_pix.blue_out  = r_blue;

`ifndef SYNTHESIS
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last |=> (r_gvalid && r_state == ST_OUT))
        else $error("gain commit did not lead to output");

    a_direct_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_direct |=> r_ovalid)
        else $error("correct beat with valid gains gave no output");

    a_acc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.acc || w_ctl.clr) |=> !r_gvalid)
        else $error("gains still marked valid after statistics change");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> !r_ovalid)
        else $error("output register busy when divided pixel completes");
`endif

endmodule
